// ===== hw/rtl/bounded_deque_with_count_and_index_top_defines.svh =====
`ifndef BOUNDED_DEQUE_WITH_COUNT_AND_INDEX_TOP_DEFINES_SVH
`define BOUNDED_DEQUE_WITH_COUNT_AND_INDEX_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define BDQ_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define BDQ_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/bdq_pkg.sv =====
`timescale 1ns / 1ps

package bdq_pkg;

    localparam int DEPTH  = 256;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    localparam int REQ_W  = 3;
    localparam int VAL_W  = 32;
    localparam int POS_W  = 8;
    localparam int MCNT_W = 9;
    localparam int FPOS_W = 8;
    localparam int ST_W   = 3;

    localparam int S_DATA_W = ((VAL_W + POS_W + 7) / 8) * 8;
    localparam int M_FLD_W  = VAL_W + MCNT_W + FPOS_W;
    localparam int M_DATA_W = ((M_FLD_W + 7) / 8) * 8;

    localparam logic [REQ_W-1:0] REQ_PUSH_HEAD = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_TAIL = 3'd1;
    localparam logic [REQ_W-1:0] REQ_POP_HEAD  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_POP_TAIL  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_COUNT     = 3'd4;
    localparam logic [REQ_W-1:0] REQ_READ_AT   = 3'd5;
    localparam logic [REQ_W-1:0] REQ_FIND      = 3'd6;

    localparam logic [ST_W-1:0] STAT_OK        = 3'd0;
    localparam logic [ST_W-1:0] STAT_FULL      = 3'd1;
    localparam logic [ST_W-1:0] STAT_EMPTY     = 3'd2;
    localparam logic [ST_W-1:0] STAT_RANGE     = 3'd3;
    localparam logic [ST_W-1:0] STAT_NOT_FOUND = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic load_req;
        logic exec;
        logic scan_step;
        logic load_result;
    } bdq_cmd_t;

    typedef struct packed {
        logic is_scan;
        logic scan_done;
        logic out_free;
    } bdq_stat_t;

    // ring address of the entry at offset off from base
    function automatic logic [ADDR_W-1:0] ring_add(input logic [ADDR_W-1:0] base,
                                                  input logic [CNT_W-1:0]  off);
        logic [CNT_W:0] sum;
        sum = {{(CNT_W + 1 - ADDR_W){1'b0}}, base} + {1'b0, off};
        if (sum >= (CNT_W + 1)'(DEPTH)) begin
            sum = sum - (CNT_W + 1)'(DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/bdq_ctrl.sv =====
`timescale 1ns / 1ps

module bdq_ctrl import bdq_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  bdq_stat_t stat,
    output bdq_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_EXEC;
            end
            ST_EXEC: begin
                state_next = stat.is_scan ? ST_SCAN : ST_RESULT;
            end
            ST_SCAN: begin
                if (stat.scan_done) state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (stat.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready     = 1'b1;
                cmd.load_req = s_tvalid;
            end
            ST_EXEC: begin
                cmd.exec = 1'b1;
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
            end
            ST_RESULT: begin
                cmd.load_result = stat.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== hw/rtl/bdq_dp.sv =====
`timescale 1ns / 1ps
`include "bounded_deque_with_count_and_index_top_defines.svh"

module bdq_dp import bdq_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic [REQ_W-1:0]         in_req_type,
    input  logic signed [VAL_W-1:0]  in_value,
    input  logic [POS_W-1:0]         in_position,
    input  bdq_cmd_t                 cmd,
    output bdq_stat_t                stat,
    input  logic                     m_tready,
    output logic                     m_tvalid,
    output logic signed [VAL_W-1:0]  out_read_value,
    output logic [MCNT_W-1:0]        out_match_count,
    output logic [FPOS_W-1:0]        out_found_position,
    output logic [ST_W-1:0]          out_status
);

    localparam int EXT_W = CNT_W + POS_W;

    logic signed [VAL_W-1:0] mem [DEPTH];

    logic [REQ_W-1:0]        req_reg;
    logic signed [VAL_W-1:0] value_reg;
    logic [POS_W-1:0]        pos_reg;

    logic [ADDR_W-1:0] front_reg, front_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [ST_W-1:0]   status_reg, status_next;

    logic [CNT_W-1:0]  scan_idx_reg, scan_idx_next;
    logic              pipe_valid_reg, pipe_valid_next;
    logic [ADDR_W-1:0] pipe_idx_reg, pipe_idx_next;
    logic [CNT_W-1:0]  match_cnt_reg, match_cnt_next;
    logic              hit_reg, hit_next;
    logic [ADDR_W-1:0] found_reg, found_next;

    logic signed [VAL_W-1:0] rd_data_reg;

    logic              m_valid_reg;
    logic signed [VAL_W-1:0] rv_reg;
    logic [MCNT_W-1:0] mc_reg;
    logic [FPOS_W-1:0] fp_reg;
    logic [ST_W-1:0]   st_reg;

    logic              full, empty, pos_oob, is_push, scan_issue;
    logic              wr_en, rd_en;
    logic [ADDR_W-1:0] front_dec, wr_addr, rd_addr;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign pos_oob = (EXT_W'(pos_reg) >= EXT_W'(count_reg));
    assign is_push = (req_reg == REQ_PUSH_HEAD) || (req_reg == REQ_PUSH_TAIL);

    assign front_dec = (front_reg == '0) ? ADDR_W'(DEPTH - 1) : front_reg - 1'b1;
    assign wr_addr   = (req_reg == REQ_PUSH_HEAD) ? front_dec : ring_add(front_reg, count_reg);
    assign wr_en     = cmd.exec && is_push && !full;

    assign scan_issue = cmd.scan_step && (scan_idx_reg < count_reg);
    assign rd_en      = (cmd.exec && (req_reg == REQ_READ_AT) && !pos_oob) || scan_issue;
    assign rd_addr    = scan_issue ? ring_add(front_reg, scan_idx_reg)
                                   : ring_add(front_reg, CNT_W'(pos_reg));

    // single-port style store: one write or one read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= value_reg;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            req_reg   <= in_req_type;
            value_reg <= in_value;
            pos_reg   <= in_position;
        end
    end

    always_comb begin
        front_next  = front_reg;
        count_next  = count_reg;
        status_next = status_reg;
        if (cmd.exec) begin
            status_next = STAT_OK;
            unique case (req_reg)
                REQ_PUSH_HEAD: begin
                    if (full) begin
                        status_next = STAT_FULL;
                    end else begin
                        front_next = front_dec;
                        count_next = count_reg + 1'b1;
                    end
                end
                REQ_PUSH_TAIL: begin
                    if (full) status_next = STAT_FULL;
                    else      count_next  = count_reg + 1'b1;
                end
                REQ_POP_HEAD: begin
                    if (empty) begin
                        status_next = STAT_EMPTY;
                    end else begin
                        front_next = ring_add(front_reg, CNT_W'(1));
                        count_next = count_reg - 1'b1;
                    end
                end
                REQ_POP_TAIL: begin
                    if (empty) status_next = STAT_EMPTY;
                    else       count_next  = count_reg - 1'b1;
                end
                REQ_READ_AT: begin
                    if (pos_oob) status_next = STAT_RANGE;
                end
                default: begin
                    status_next = STAT_OK;
                end
            endcase
        end
    end

    // scan: address issued one cycle, compared the next against registered data
    always_comb begin
        scan_idx_next   = scan_idx_reg;
        pipe_valid_next = 1'b0;
        pipe_idx_next   = pipe_idx_reg;
        match_cnt_next  = match_cnt_reg;
        hit_next        = hit_reg;
        found_next      = found_reg;
        if (cmd.exec) begin
            scan_idx_next  = '0;
            match_cnt_next = '0;
            hit_next       = 1'b0;
            found_next     = '0;
        end else begin
            if (scan_issue) begin
                scan_idx_next   = scan_idx_reg + 1'b1;
                pipe_valid_next = 1'b1;
                pipe_idx_next   = scan_idx_reg[ADDR_W-1:0];
            end
            if (pipe_valid_reg && (rd_data_reg == value_reg)) begin
                match_cnt_next = match_cnt_reg + 1'b1;
                if (!hit_reg) begin
                    hit_next   = 1'b1;
                    found_next = pipe_idx_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg      <= '0;
            count_reg      <= '0;
            pipe_valid_reg <= 1'b0;
        end else begin
            front_reg      <= front_next;
            count_reg      <= count_next;
            pipe_valid_reg <= pipe_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg    <= status_next;
        scan_idx_reg  <= scan_idx_next;
        pipe_idx_reg  <= pipe_idx_next;
        match_cnt_reg <= match_cnt_next;
        hit_reg       <= hit_next;
        found_reg     <= found_next;
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_result) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_result) begin
            rv_reg <= ((req_reg == REQ_READ_AT) && (status_reg == STAT_OK)) ? rd_data_reg : '0;
            mc_reg <= (req_reg == REQ_COUNT) ? MCNT_W'(match_cnt_reg) : '0;
            fp_reg <= ((req_reg == REQ_FIND) && hit_reg) ? FPOS_W'(found_reg) : '0;
            st_reg <= ((req_reg == REQ_FIND) && !hit_reg) ? STAT_NOT_FOUND : status_reg;
        end
    end

    assign stat.is_scan   = (req_reg == REQ_COUNT) || (req_reg == REQ_FIND);
    assign stat.scan_done = (scan_idx_reg >= count_reg) && !pipe_valid_reg;
    assign stat.out_free  = !m_valid_reg || m_tready;

    assign m_tvalid           = m_valid_reg;
    assign out_read_value     = rv_reg;
    assign out_match_count    = mc_reg;
    assign out_found_position = fp_reg;
    assign out_status         = st_reg;

    `BDQ_ASSERT_IMP(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_W'(DEPTH), "entry count above depth")
    `BDQ_ASSERT_NXT(a_tail_push_grows, aclk, aresetn, cmd.exec && (req_reg == REQ_PUSH_TAIL) && !full, count_reg == $past(count_reg) + 1'b1, "tail push did not add an entry")
    `BDQ_ASSERT_IMP(a_match_le_scanned, aclk, aresetn, pipe_valid_reg, match_cnt_reg < scan_idx_reg, "more matches than entries compared")

endmodule

// ===== hw/rtl/bounded_deque_with_count_and_index_top.sv =====
`timescale 1ns / 1ps

// Bounded double-ended queue of signed 32-bit values in a ring of DEPTH (256) entries held in
// a one-port memory. Each input beat carries one request (push front or back, pop front or back,
// count entries equal to a value, read the entry at a position from the front, find the first
// entry equal to a value) and yields exactly one result beat with read value, match count,
// found position and status. The block works on one request at a time: pushes, pops, read-at
// and the unused request code go from execution straight to the result, while count and find
// first walk the live entries from front to back at one memory read per cycle. A finished
// result sits in an output register, so the next request is taken while it waits for
// m_tready; that request then holds in its last cycle until the waiting beat leaves. No
// memory clearing is needed after reset.
module bounded_deque_with_count_and_index_top import bdq_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // value[31:0], position[39:32]
    input  logic [REQ_W-1:0]    s_tuser,   // req_type[2:0]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // read_value[31:0], match_count[40:32],
                                           // found_position[48:41], zero pad above
    output logic [ST_W-1:0]     m_tuser    // status[2:0]
);

    bdq_cmd_t  cmd;
    bdq_stat_t stat;

    logic signed [VAL_W-1:0] read_value;
    logic [MCNT_W-1:0]       match_count;
    logic [FPOS_W-1:0]       found_position;

    bdq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bdq_dp u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .in_req_type        (s_tuser),
        .in_value           (s_tdata[VAL_W-1:0]),
        .in_position        (s_tdata[VAL_W+POS_W-1:VAL_W]),
        .cmd                (cmd),
        .stat               (stat),
        .m_tready           (m_tready),
        .m_tvalid           (m_tvalid),
        .out_read_value     (read_value),
        .out_match_count    (match_count),
        .out_found_position (found_position),
        .out_status         (m_tuser)
    );

    assign m_tdata = {{(M_DATA_W - M_FLD_W){1'b0}}, found_position, match_count, read_value};

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import bdq_pkg::*;

    // code with no defined operation, the block must answer with all zeros
    localparam logic [REQ_W-1:0] REQ_UNUSED = 3'd7;
    localparam int QUIET_LIMIT = 5000;
    localparam int SETTLE_CYCLES = 300;

    typedef struct packed {
        logic [VAL_W-1:0]  read_value;
        logic [MCNT_W-1:0] match_count;
        logic [FPOS_W-1:0] found_position;
        logic [ST_W-1:0]   status;
    } deque_result_t;

    class deque_scoreboard;
        logic [VAL_W-1:0] ring [DEPTH];
        int unsigned head;
        int unsigned fill;
        deque_result_t expected_results [$];
        int errors;

        function new();
            head = 0;
            fill = 0;
            errors = 0;
        endfunction

        function logic [VAL_W-1:0] entry_at(input int unsigned k);
            return ring[(head + k) % DEPTH];
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // update the shadow deque for one accepted request and queue its answer
        function void note_request(input logic [REQ_W-1:0] req, input logic [VAL_W-1:0] val,
                                   input logic [POS_W-1:0] pos);
            deque_result_t r;
            int unsigned k;
            bit hit;
            r = '0;
            hit = 0;
            case (req)
                REQ_PUSH_HEAD: begin
                    if (fill >= DEPTH) begin
                        r.status = STAT_FULL;
                    end else begin
                        head = (head + DEPTH - 1) % DEPTH;
                        ring[head] = val;
                        fill++;
                    end
                end
                REQ_PUSH_TAIL: begin
                    if (fill >= DEPTH) begin
                        r.status = STAT_FULL;
                    end else begin
                        ring[(head + fill) % DEPTH] = val;
                        fill++;
                    end
                end
                REQ_POP_HEAD: begin
                    if (fill == 0) begin
                        r.status = STAT_EMPTY;
                    end else begin
                        head = (head + 1) % DEPTH;
                        fill--;
                    end
                end
                REQ_POP_TAIL: begin
                    if (fill == 0) begin
                        r.status = STAT_EMPTY;
                    end else begin
                        fill--;
                    end
                end
                REQ_COUNT: begin
                    for (k = 0; k < fill; k++) begin
                        if (entry_at(k) == val) r.match_count++;
                    end
                end
                REQ_READ_AT: begin
                    if (pos >= fill) r.status = STAT_RANGE;
                    else r.read_value = entry_at(pos);
                end
                REQ_FIND: begin
                    for (k = 0; k < fill && !hit; k++) begin
                        if (entry_at(k) == val) begin
                            r.found_position = k[FPOS_W-1:0];
                            hit = 1;
                        end
                    end
                    if (!hit) r.status = STAT_NOT_FOUND;
                end
                default: begin
                end
            endcase
            expected_results = {expected_results, r};
        endfunction

        function void check_result(input logic [M_DATA_W-1:0] data, input logic [ST_W-1:0] user);
            deque_result_t e;
            if (expected_results.size() == 0) begin
                $error("result beat with no request waiting: tdata %h tuser %h", data, user);
                errors++;
                return;
            end
            e = expected_results[0];
            expected_results.delete(0);
            if (data[31:0] !== e.read_value) begin
                $error("read_value expected %0d actual %0d", $signed(e.read_value),
                       $signed(data[31:0]));
                errors++;
            end
            if (data[40:32] !== e.match_count) begin
                $error("match_count expected %0d actual %0d", e.match_count, data[40:32]);
                errors++;
            end
            if (data[48:41] !== e.found_position) begin
                $error("found_position expected %0d actual %0d", e.found_position, data[48:41]);
                errors++;
            end
            if (data[M_DATA_W-1:49] !== '0) begin
                $error("pad expected 0 actual %h", data[M_DATA_W-1:49]);
                errors++;
            end
            if (user !== e.status) begin
                $error("status expected %0d actual %0d", e.status, user);
                errors++;
            end
        endfunction
    endclass

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic [REQ_W-1:0]    s_tuser;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic [ST_W-1:0]     m_tuser;

    deque_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int quiet_cycles = 0;

    bounded_deque_with_count_and_index_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // result side: random back-pressure and checking of every beat taken
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    function automatic logic [VAL_W-1:0] pick_value();
        if ($urandom_range(9) < 6) begin
            case ($urandom_range(7))
                0: return 32'h0000_0000;
                1: return 32'h0000_0001;
                2: return 32'hffff_ffff;
                3: return 32'h8000_0000;
                4: return 32'h7fff_ffff;
                5: return 32'h5555_5555;
                6: return 32'haaaa_aaaa;
                default: return 32'h0000_0007;
            endcase
        end
        return $urandom();
    endfunction

    task automatic send_request(input logic [REQ_W-1:0] req, input logic [VAL_W-1:0] val,
                                input logic [POS_W-1:0] pos);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_W'({pos, val});
        s_tuser  <= req;
        do @(posedge aclk); while (!s_tready);
        sb.note_request(req, val, pos);
    endtask

    task automatic random_request(input int bias);
        int unsigned r;
        int unsigned k;
        int push_pct;
        int pop_pct;
        logic [REQ_W-1:0] req;
        logic [VAL_W-1:0] val;
        logic [POS_W-1:0] pos;
        push_pct = (bias == 0) ? 50 : (bias == 1) ? 12 : 30;
        pop_pct  = (bias == 0) ? 8 : (bias == 1) ? 45 : 25;
        r = $urandom_range(99);
        val = pick_value();
        pos = POS_W'($urandom_range(255));
        if (r < push_pct) begin
            req = $urandom_range(1) ? REQ_PUSH_TAIL : REQ_PUSH_HEAD;
        end else if (r < push_pct + pop_pct) begin
            req = $urandom_range(1) ? REQ_POP_TAIL : REQ_POP_HEAD;
        end else if (r < 98) begin
            case ($urandom_range(2))
                0: req = REQ_COUNT;
                1: req = REQ_READ_AT;
                default: req = REQ_FIND;
            endcase
            // mostly aim at a live entry so reads land and searches hit
            if (sb.fill != 0 && $urandom_range(9) < 7) begin
                k = $urandom_range(sb.fill - 1);
                pos = k[POS_W-1:0];
                if (req != REQ_READ_AT) val = sb.entry_at(k);
            end
        end else begin
            req = REQ_UNUSED;
        end
        send_request(req, val, pos);
    endtask

    // drop valid so the last beat is not taken twice, then wait for every answer
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    initial begin
        int phase;
        int seg;
        int n;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= REQ_PUSH_HEAD;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty store corner cases
        send_request(REQ_POP_HEAD, 32'h0, 8'h00);
        send_request(REQ_POP_TAIL, 32'h0, 8'hff);
        send_request(REQ_READ_AT, 32'h0, 8'h00);
        send_request(REQ_COUNT, 32'h0, 8'h00);
        send_request(REQ_FIND, 32'h0, 8'h00);
        send_request(REQ_UNUSED, 32'h1234_5678, 8'h5a);
        // extremes at both ends
        send_request(REQ_PUSH_TAIL, 32'h7fff_ffff, 8'h00);
        send_request(REQ_PUSH_HEAD, 32'h8000_0000, 8'hff);
        send_request(REQ_PUSH_TAIL, 32'hffff_ffff, 8'h00);
        send_request(REQ_PUSH_HEAD, 32'h0000_0000, 8'h00);
        send_request(REQ_READ_AT, 32'h0, 8'd0);
        send_request(REQ_READ_AT, 32'h0, 8'd3);
        send_request(REQ_READ_AT, 32'h0, 8'd4);
        send_request(REQ_READ_AT, 32'hffff_ffff, 8'd255);
        send_request(REQ_COUNT, 32'hffff_ffff, 8'h00);
        send_request(REQ_FIND, 32'h7fff_ffff, 8'h00);
        send_request(REQ_FIND, 32'd123, 8'h00);
        send_request(REQ_PUSH_TAIL, 32'h7fff_ffff, 8'h00);
        send_request(REQ_COUNT, 32'h7fff_ffff, 8'h00);
        send_request(REQ_POP_HEAD, 32'h0, 8'h00);
        send_request(REQ_POP_TAIL, 32'h0, 8'h00);
        send_request(REQ_POP_HEAD, 32'h0, 8'h00);
        send_request(REQ_POP_TAIL, 32'h0, 8'h00);
        send_request(REQ_POP_TAIL, 32'h0, 8'h00);
        send_request(REQ_UNUSED, 32'hffff_ffff, 8'hff);

        for (phase = 0; phase < 4; phase++) begin
            wait_results_drained();
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
                default: begin send_idle_pct = 14; recv_stall_pct = 14; end
            endcase
            if (phase == 0) begin
                // fill to the brim, overflow, then empty out past the bottom
                while (sb.fill < DEPTH) begin
                    send_request($urandom_range(1) ? REQ_PUSH_TAIL : REQ_PUSH_HEAD,
                                 pick_value(), POS_W'($urandom_range(255)));
                end
                for (n = 0; n < 3; n++) begin
                    send_request(n[0] ? REQ_PUSH_HEAD : REQ_PUSH_TAIL, pick_value(), 8'h00);
                end
                send_request(REQ_READ_AT, 32'h0, 8'd255);
                send_request(REQ_FIND, sb.entry_at(DEPTH - 1), 8'h00);
                send_request(REQ_COUNT, pick_value(), 8'h00);
                while (sb.fill != 0) begin
                    if ($urandom_range(7) == 0) begin
                        send_request(REQ_READ_AT, 32'h0, POS_W'($urandom_range(sb.fill - 1)));
                    end else begin
                        send_request($urandom_range(1) ? REQ_POP_TAIL : REQ_POP_HEAD,
                                     32'h0, 8'h00);
                    end
                end
                send_request(REQ_POP_HEAD, 32'h0, 8'h00);
                send_request(REQ_POP_TAIL, 32'h0, 8'h00);
            end
            for (seg = 0; seg < 6; seg++) begin
                // sender holds off until the block has answered everything
                if (seg == 3) wait_results_drained();
                n = $urandom_range(2);
                repeat (50) random_request(n);
            end
        end

        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
